// ----- rtl/parallel_adc_conversion_reader_defines.svh -----
// Assertion macros shared by the parallel ADC conversion reader.
// Included by the top level; no other dependencies.
`ifndef PARALLEL_ADC_CONVERSION_READER_DEFINES_SVH
`define PARALLEL_ADC_CONVERSION_READER_DEFINES_SVH

`ifndef SYNTHESIS
// A property that must hold on every clock edge outside reset.
`define PACR_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A condition on one edge that forces a consequence on the next edge.
`define PACR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PACR_ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define PACR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/pacr_pkg.sv -----
// Types, codes and constants of the parallel ADC conversion reader.
// Used by every module of the block but pacr_out_buffer; depends on nothing.
`timescale 1ns / 1ps

package pacr_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 6;

   localparam int CMD_W      = 2;
   localparam int BUS_W      = 16;
   localparam int SAMPLE_W   = 12;
   localparam int CHANNEL_W  = 3;
   localparam int TICK_W     = 12;
   localparam int TIMEOUT_W  = 10;
   localparam int HOLD_W     = 8;
   localparam int RST_HOLD_W = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [TIMEOUT_W-1:0]  BUSY_TIMEOUT_RESET = 10'd10;
   localparam logic [HOLD_W-1:0]     CONVST_HOLD_RESET  = 8'd2;
   localparam logic [RST_HOLD_W-1:0] RESET_HOLD_RESET   = 12'd1000;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE  = 2'd0,
      CMD_START = 2'd1,
      CMD_RESET = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BUSY_TIMEOUT = 3'd0,
      REG_CONVST_HOLD  = 3'd1,
      REG_RESET_HOLD   = 3'd2,
      REG_RANGE_SEL    = 3'd3,
      REG_REF_SEL      = 3'd4
   } reg_index_type;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_HOLD = 6'b000010,
      PH_WAIT = 6'b000100,
      PH_RDLO = 6'b001000,
      PH_RDHI = 6'b010000,
      PH_RST  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0]  busy_timeout;
      logic [HOLD_W-1:0]     convst_hold;
      logic [RST_HOLD_W-1:0] reset_hold;
      logic                  range_select;
      logic                  reference_select;
   } cfg_type;

   typedef struct packed {
      logic                       last_sample;
      logic                       sample_valid;
      logic                       engaged;
      logic                       timeout_error;
      logic signed [SAMPLE_W-1:0] sample;
      logic [CHANNEL_W-1:0]       channel;
      logic                       reference_level;
      logic                       range_level;
      logic                       reset_level;
      logic                       read_strobe_n;
      logic                       chip_select_n;
      logic                       convst_level;
   } rsp_type;

endpackage

// ----- rtl/pacr_csr.sv -----
// Configuration registers of the parallel ADC conversion reader.
// Depends on pacr_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module pacr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [pacr_pkg::CSR_IDX_W-1:0]     wr_index,
   input  logic [pacr_pkg::CSR_DATA_W-1:0]    wr_data,
   output pacr_pkg::cfg_type                  cfg
);

   pacr_pkg::cfg_type cfg_ff;
   pacr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            pacr_pkg::REG_BUSY_TIMEOUT: begin
               cfg_in.busy_timeout = wr_data[pacr_pkg::TIMEOUT_W-1:0];
            end
            pacr_pkg::REG_CONVST_HOLD: begin
               cfg_in.convst_hold = wr_data[pacr_pkg::HOLD_W-1:0];
            end
            pacr_pkg::REG_RESET_HOLD: begin
               cfg_in.reset_hold = wr_data[pacr_pkg::RST_HOLD_W-1:0];
            end
            pacr_pkg::REG_RANGE_SEL: begin
               cfg_in.range_select = wr_data[0];
            end
            pacr_pkg::REG_REF_SEL: begin
               cfg_in.reference_select = wr_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.busy_timeout     <= pacr_pkg::BUSY_TIMEOUT_RESET;
         cfg_ff.convst_hold      <= pacr_pkg::CONVST_HOLD_RESET;
         cfg_ff.reset_hold       <= pacr_pkg::RESET_HOLD_RESET;
         cfg_ff.range_select     <= 1'b0;
         cfg_ff.reference_select <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/pacr_sequencer.sv -----
// Pin sequencer of the parallel ADC conversion reader: phase, tick counter,
// channel counter and pin registers, advanced once per accepted tick beat.
// Depends on pacr_pkg.
`timescale 1ns / 1ps

module pacr_sequencer #(
   parameter int NUM_CHANNELS = pacr_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [pacr_pkg::CMD_W-1:0]      cmd,
   input  logic                            busy_level,
   input  logic [pacr_pkg::BUS_W-1:0]      data_bus,
   input  pacr_pkg::cfg_type               cfg,
   output pacr_pkg::rsp_type               result
);

   localparam logic [pacr_pkg::CHANNEL_W:0] LAST_COUNT = (pacr_pkg::CHANNEL_W+1)'(NUM_CHANNELS);

   pacr_pkg::phase_type               phase_ff, phase_in;
   logic [pacr_pkg::TICK_W-1:0]       tick_ff, tick_in;
   logic [pacr_pkg::CHANNEL_W-1:0]    chan_ff, chan_in;
   logic                              convst_ff, convst_in;
   logic                              cs_n_ff, cs_n_in;
   logic                              rd_n_ff, rd_n_in;
   logic                              rst_pin_ff, rst_pin_in;

   logic [pacr_pkg::TICK_W-1:0]       tick_inc;
   logic [pacr_pkg::TICK_W-1:0]       wait_count;
   logic                              hold_done;
   logic                              rst_done;
   logic                              wait_expired;
   logic                              on_last;
   logic                              do_wait;
   logic                              valid;
   logic                              timeout;

   assign tick_inc  = tick_ff + 1'b1;
   assign hold_done = tick_ff >= {{(pacr_pkg::TICK_W-pacr_pkg::HOLD_W){1'b0}}, cfg.convst_hold};
   assign rst_done  = tick_ff >= cfg.reset_hold;
   // When the hold ends the busy wait starts on the same tick with a fresh count.
   assign wait_count   = (phase_ff == pacr_pkg::PH_HOLD) ? pacr_pkg::TICK_W'(1) : tick_inc;
   assign wait_expired = wait_count >=
                         {{(pacr_pkg::TICK_W-pacr_pkg::TIMEOUT_W){1'b0}}, cfg.busy_timeout};
   assign on_last      = ({1'b0, chan_ff} + 1'b1) >= LAST_COUNT;

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      chan_in    = chan_ff;
      convst_in  = convst_ff;
      cs_n_in    = cs_n_ff;
      rd_n_in    = rd_n_ff;
      rst_pin_in = rst_pin_ff;
      do_wait    = 1'b0;
      valid      = 1'b0;
      timeout    = 1'b0;

      case (phase_ff)
         pacr_pkg::PH_IDLE: begin
            if (cmd == pacr_pkg::CMD_START) begin
               convst_in = 1'b1;
               cs_n_in   = 1'b1;
               rd_n_in   = 1'b1;
               tick_in   = pacr_pkg::TICK_W'(1);
               phase_in  = pacr_pkg::PH_HOLD;
            end else if (cmd == pacr_pkg::CMD_RESET) begin
               rst_pin_in = 1'b1;
               tick_in    = pacr_pkg::TICK_W'(1);
               phase_in   = pacr_pkg::PH_RST;
            end
         end
         pacr_pkg::PH_HOLD: begin
            if (hold_done) begin
               do_wait = 1'b1;
            end else begin
               tick_in = tick_inc;
            end
         end
         pacr_pkg::PH_WAIT: begin
            do_wait = 1'b1;
         end
         pacr_pkg::PH_RDLO: begin
            rd_n_in  = 1'b0;
            valid    = 1'b1;
            phase_in = pacr_pkg::PH_RDHI;
         end
         pacr_pkg::PH_RDHI: begin
            rd_n_in = 1'b1;
            if (on_last) begin
               cs_n_in   = 1'b1;
               convst_in = 1'b0;
               chan_in   = '0;
               phase_in  = pacr_pkg::PH_IDLE;
            end else begin
               chan_in  = chan_ff + 1'b1;
               phase_in = pacr_pkg::PH_RDLO;
            end
         end
         pacr_pkg::PH_RST: begin
            if (rst_done) begin
               rst_pin_in = 1'b0;
               tick_in    = '0;
               phase_in   = pacr_pkg::PH_IDLE;
            end else begin
               tick_in = tick_inc;
            end
         end
         default: begin
            phase_in = pacr_pkg::PH_IDLE;
         end
      endcase

      // Busy low takes precedence over an expiring timeout.
      if (do_wait) begin
         if (!busy_level) begin
            cs_n_in  = 1'b0;
            chan_in  = '0;
            tick_in  = '0;
            phase_in = pacr_pkg::PH_RDLO;
         end else if (wait_expired) begin
            timeout  = 1'b1;
            cs_n_in  = 1'b1;
            tick_in  = '0;
            phase_in = pacr_pkg::PH_IDLE;
         end else begin
            tick_in  = wait_count;
            phase_in = pacr_pkg::PH_WAIT;
         end
      end
   end

   always_comb begin
      result.convst_level    = convst_in;
      result.chip_select_n   = cs_n_in;
      result.read_strobe_n   = rd_n_in;
      result.reset_level     = rst_pin_in;
      result.range_level     = ~cfg.range_select;
      result.reference_level = ~cfg.reference_select;
      result.sample_valid    = valid;
      result.channel         = valid ? chan_ff : '0;
      result.sample          = valid ? data_bus[pacr_pkg::SAMPLE_W-1:0] : '0;
      result.last_sample     = valid & on_last;
      result.timeout_error   = timeout;
      result.engaged         = phase_in != pacr_pkg::PH_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= pacr_pkg::PH_IDLE;
         tick_ff    <= '0;
         chan_ff    <= '0;
         convst_ff  <= 1'b1;
         cs_n_ff    <= 1'b1;
         rd_n_ff    <= 1'b1;
         rst_pin_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         chan_ff    <= chan_in;
         convst_ff  <= convst_in;
         cs_n_ff    <= cs_n_in;
         rd_n_ff    <= rd_n_in;
         rst_pin_ff <= rst_pin_in;
      end
   end

endmodule

// ----- rtl/pacr_out_buffer.sv -----
// Result register with a skid stage, so that a new beat is taken while a
// finished one still waits. Generic in width; no package dependencies.
`timescale 1ns / 1ps

module pacr_out_buffer #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             main_valid_ff, main_valid_in;
   logic [WIDTH-1:0] main_data_ff, main_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;

   assign in_ready = ~skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_data_in  = in_data;
         end
      end else if (in_valid && !skid_valid_ff) begin
         // Output stalled: park the new beat in the skid stage.
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

// ----- rtl/parallel_adc_conversion_reader.sv -----
// Parallel ADC conversion reader: six-channel pin sequencer, one tick per beat.
// Usage: every req beat is one timing tick carrying a command (none, start
// conversion or reset pulse), the sampled busy pin and the sampled data bus.
// Every accepted req beat yields exactly one rsp beat holding the pin levels
// in force after that tick, plus a signed sample on RD low ticks (rsp_tuser
// high, rsp_tlast high on the final channel) and a timeout flag.
// Output: the rsp beat is registered, via the skid stage when the output stalls.
// Throughput: one beat per cycle while rsp_tready is high, set by the single
// pass of sequencer next-state logic between its state and the result register.
// Stall: when rsp_tready is low, one further beat is parked in a skid stage;
// req_tready then drops until the output drains.
// Reset: synchronous, active high; the sequencer returns to idle with
// convert-start and chip select high, RD high and the reset pin low, and the
// configuration registers take their default values.
// Configuration: csr writes are always accepted; they should be issued only
// while no conversion or reset sequence is running.
// Depends on pacr_pkg, pacr_csr, pacr_sequencer, pacr_out_buffer.
`timescale 1ns / 1ps
`include "parallel_adc_conversion_reader_defines.svh"

module parallel_adc_conversion_reader #(
   parameter int NUM_CHANNELS = pacr_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Tick beats in.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // cmd[1:0], busy_level[2], data_bus[18:3], zero pad [23:19]
   input  logic [23:0]                     req_tdata,
   // Result beats out.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // convst_level[0], chip_select_n[1], read_strobe_n[2], reset_level[3],
   // range_level[4], reference_level[5], channel[8:6], sample[20:9],
   // timeout_error[21], engaged[22], zero pad [23]
   output logic [23:0]                     rsp_tdata,
   // sample_valid[0]
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   // Configuration writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pacr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pacr_pkg::CSR_DATA_W-1:0] csr_data
);

   pacr_pkg::cfg_type cfg;
   pacr_pkg::rsp_type seq_result;
   pacr_pkg::rsp_type out_result;
   logic              step;

   assign csr_ready = 1'b1;
   assign step      = req_tvalid & req_tready;

   pacr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   pacr_sequencer #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cmd        (req_tdata[1:0]),
      .busy_level (req_tdata[2]),
      .data_bus   (req_tdata[18:3]),
      .cfg        (cfg),
      .result     (seq_result)
   );

   pacr_out_buffer #(
      .WIDTH ($bits(pacr_pkg::rsp_type))
   ) u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (seq_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   assign rsp_tdata = {1'b0,
                       out_result.engaged,
                       out_result.timeout_error,
                       out_result.sample,
                       out_result.channel,
                       out_result.reference_level,
                       out_result.range_level,
                       out_result.reset_level,
                       out_result.read_strobe_n,
                       out_result.chip_select_n,
                       out_result.convst_level};
   assign rsp_tuser = out_result.sample_valid;
   assign rsp_tlast = out_result.last_sample;

   `PACR_ASSERT_NEXT(a_accept_gives_beat, clock, reset, req_tvalid && req_tready, rsp_tvalid,
      "accepted tick beat did not produce a result beat")
   `PACR_ASSERT_ALWAYS(a_last_is_sample, clock, reset, !(rsp_tvalid && rsp_tlast) || rsp_tuser,
      "last flag without a captured sample")
   `PACR_ASSERT_ALWAYS(a_sample_pins, clock, reset,
      !(rsp_tvalid && rsp_tuser) || (!rsp_tdata[1] && !rsp_tdata[2]),
      "sample captured without chip select and RD low")
   `PACR_ASSERT_ALWAYS(a_timeout_not_sample, clock, reset,
      !(rsp_tvalid && rsp_tdata[21] && rsp_tuser),
      "timeout flagged on a sample beat")

endmodule

// ----- tb/sv/tb_parallel_adc_conversion_reader.sv -----
// Self-checking testbench for the parallel ADC conversion reader: directed ticks, then
// random conversion and reset sequences under several register settings and handshake loads.
// Depends on pacr_pkg and the parallel_adc_conversion_reader top level.
`timescale 1ns / 1ps

module tb_parallel_adc_conversion_reader;

   localparam int NUM_CHANNELS = pacr_pkg::NUM_CHANNELS_DEFAULT;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int NUM_PHASES = 6;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam logic [pacr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [pacr_pkg::CMD_W-1:0]           cmd;
      logic                                 busy;
      logic [pacr_pkg::BUS_W-1:0]           bus;
      logic                                 known;
      logic                                 valid;
      logic signed [pacr_pkg::SAMPLE_W-1:0] samp;
      logic                                 terr;
   } tick_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [23:0]                     req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [23:0]                     rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [pacr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pacr_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Predicted sequencer state and register contents.
   pacr_pkg::phase_type             seq_phase;
   logic [pacr_pkg::TICK_W-1:0]     seq_ticks;
   logic [pacr_pkg::CHANNEL_W-1:0]  seq_chan;
   logic                            convst_q, cs_q, rd_q, rstpin_q;
   pacr_pkg::cfg_type               cfg;

   pacr_pkg::rsp_type               pins_due [$];
   pacr_pkg::rsp_type               due_beat;
   int                              failures = 0;
   int unsigned                     send_idle_pct = 0;
   int unsigned                     recv_stall_pct = 0;
   int                              hold_requests = 0;
   int                              holds_served = 0;
   int                              hold_left = 0;
   int unsigned                     cycles_run = 0;
   int                              since_start = 0;
   int                              busy_len = 0;

   tick_row_type directed_ticks [28] = '{
      '{pacr_pkg::CMD_START, 1'b1, 16'h0000, 1'b1, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'hFFFF, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b0, 16'h1234, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b0, 16'h0000, 1'b1, 1'b1, 0,     1'b0},
      '{pacr_pkg::CMD_START, 1'b1, 16'hAAAA, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b0, 16'h07FF, 1'b1, 1'b1, 2047,  1'b0},
      '{pacr_pkg::CMD_RESET, 1'b1, 16'h5555, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'h0800, 1'b1, 1'b1, -2048, 1'b0},
      '{CMD_UNUSED,          1'b0, 16'h0000, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b0, 16'hFFFF, 1'b1, 1'b1, -1,    1'b0},
      '{pacr_pkg::CMD_NONE,  1'b0, 16'h0000, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'hF800, 1'b1, 1'b1, -2048, 1'b0},
      '{pacr_pkg::CMD_START, 1'b0, 16'h0000, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b0, 16'h0001, 1'b1, 1'b1, 1,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b0, 16'hFFFF, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_START, 1'b0, 16'h0000, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b0, 16'h0000, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'h0F0F, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'h0F0F, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'h0F0F, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'h0F0F, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'h0F0F, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'h0F0F, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'h0F0F, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'h0F0F, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'h0F0F, 1'b0, 1'b0, 0,     1'b0},
      '{pacr_pkg::CMD_NONE,  1'b1, 16'hFFFF, 1'b1, 1'b0, 0,     1'b1},
      '{CMD_UNUSED,          1'b0, 16'h0000, 1'b1, 1'b0, 0,     1'b0}
   };

   parallel_adc_conversion_reader #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   task automatic clear_prediction();
      seq_phase = pacr_pkg::PH_IDLE;
      seq_ticks = '0;
      seq_chan = '0;
      convst_q = 1'b1;
      cs_q = 1'b1;
      rd_q = 1'b1;
      rstpin_q = 1'b0;
      cfg.busy_timeout = pacr_pkg::BUSY_TIMEOUT_RESET;
      cfg.convst_hold = pacr_pkg::CONVST_HOLD_RESET;
      cfg.reset_hold = pacr_pkg::RESET_HOLD_RESET;
      cfg.range_select = 1'b0;
      cfg.reference_select = 1'b0;
   endtask

   // Pin levels in force after one tick; a hold or timeout of zero behaves as one.
   function automatic pacr_pkg::rsp_type advance_pins(logic [pacr_pkg::CMD_W-1:0] cmd,
                                                      logic busy,
                                                      logic [pacr_pkg::BUS_W-1:0] bus);
      pacr_pkg::rsp_type r;
      logic watch_busy;
      r = '0;
      watch_busy = 1'b0;
      case (seq_phase)
         pacr_pkg::PH_IDLE: begin
            if (cmd == pacr_pkg::CMD_START) begin
               convst_q = 1'b1;
               cs_q = 1'b1;
               rd_q = 1'b1;
               seq_ticks = 12'd1;
               seq_phase = pacr_pkg::PH_HOLD;
            end else if (cmd == pacr_pkg::CMD_RESET) begin
               rstpin_q = 1'b1;
               seq_ticks = 12'd1;
               seq_phase = pacr_pkg::PH_RST;
            end
         end
         pacr_pkg::PH_HOLD: begin
            if (seq_ticks >= {4'd0, cfg.convst_hold}) begin
               // The hold ends and busy is looked at on this same tick.
               seq_ticks = '0;
               seq_phase = pacr_pkg::PH_WAIT;
               watch_busy = 1'b1;
            end else begin
               seq_ticks = seq_ticks + 12'd1;
            end
         end
         pacr_pkg::PH_WAIT: watch_busy = 1'b1;
         pacr_pkg::PH_RDLO: begin
            rd_q = 1'b0;
            r.sample_valid = 1'b1;
            r.channel = seq_chan;
            r.sample = bus[pacr_pkg::SAMPLE_W-1:0];
            r.last_sample = (int'(seq_chan) + 1 >= NUM_CHANNELS);
            seq_phase = pacr_pkg::PH_RDHI;
         end
         pacr_pkg::PH_RDHI: begin
            rd_q = 1'b1;
            if (int'(seq_chan) + 1 >= NUM_CHANNELS) begin
               cs_q = 1'b1;
               convst_q = 1'b0;
               seq_chan = '0;
               seq_phase = pacr_pkg::PH_IDLE;
            end else begin
               seq_chan = seq_chan + 3'd1;
               seq_phase = pacr_pkg::PH_RDLO;
            end
         end
         pacr_pkg::PH_RST: begin
            if (seq_ticks >= cfg.reset_hold) begin
               rstpin_q = 1'b0;
               seq_ticks = '0;
               seq_phase = pacr_pkg::PH_IDLE;
            end else begin
               seq_ticks = seq_ticks + 12'd1;
            end
         end
         default: seq_phase = pacr_pkg::PH_IDLE;
      endcase
      if (watch_busy) begin
         // Busy seen low starts reading even on the tick the wait would expire.
         if (!busy) begin
            cs_q = 1'b0;
            seq_chan = '0;
            seq_ticks = '0;
            seq_phase = pacr_pkg::PH_RDLO;
         end else begin
            seq_ticks = seq_ticks + 12'd1;
            if (seq_ticks >= {2'd0, cfg.busy_timeout}) begin
               r.timeout_error = 1'b1;
               cs_q = 1'b1;
               seq_ticks = '0;
               seq_phase = pacr_pkg::PH_IDLE;
            end
         end
      end
      r.convst_level = convst_q;
      r.chip_select_n = cs_q;
      r.read_strobe_n = rd_q;
      r.reset_level = rstpin_q;
      r.range_level = ~cfg.range_select;
      r.reference_level = ~cfg.reference_select;
      r.engaged = (seq_phase != pacr_pkg::PH_IDLE);
      return r;
   endfunction

   task automatic send_tick(input tick_row_type row);
      pacr_pkg::rsp_type due;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, row.bus, row.busy, row.cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      due = advance_pins(row.cmd, row.busy, row.bus);
      if (row.known) begin
         due.sample_valid = row.valid;
         due.sample = row.samp;
         due.timeout_error = row.terr;
      end
      pins_due.push_back(due);
   endtask

   // Mostly well-formed conversions whose busy pulse ends short, on the last allowed
   // tick or too late; about one tick in ten is pure noise.
   task automatic make_tick(output tick_row_type row);
      int hold_eff;
      int limit_eff;
      int roll;
      row = '0;
      row.cmd = pacr_pkg::CMD_NONE;
      row.busy = 1'($urandom_range(1));
      row.bus = 16'($urandom);
      roll = $urandom_range(9);
      if (roll == 0) row.bus = 16'h0000;
      else if (roll == 1) row.bus = 16'hFFFF;
      else if (roll == 2) row.bus = 16'h07FF;
      else if (roll == 3) row.bus = 16'h0800;
      hold_eff = (cfg.convst_hold == 0) ? 1 : int'(cfg.convst_hold);
      limit_eff = (cfg.busy_timeout == 0) ? 1 : int'(cfg.busy_timeout);
      if ($urandom_range(9) == 0) begin
         row.cmd = 2'($urandom_range(3));
         // Long reset pulses are kept rare so that the run stays short.
         if (row.cmd == pacr_pkg::CMD_RESET && cfg.reset_hold > 64) begin
            row.cmd = pacr_pkg::CMD_NONE;
         end
         return;
      end
      case (seq_phase)
         pacr_pkg::PH_IDLE: begin
            roll = $urandom_range(99);
            if (roll < ((cfg.reset_hold > 64) ? 1 : 8)) begin
               row.cmd = pacr_pkg::CMD_RESET;
            end else if (roll < 80) begin
               row.cmd = pacr_pkg::CMD_START;
               since_start = 1;
               roll = $urandom_range(99);
               if (roll < 45) busy_len = $urandom_range(2);
               else if (roll < 70) busy_len = $urandom_range(limit_eff - 1);
               else if (roll < 85) busy_len = limit_eff - 1;
               else busy_len = limit_eff + $urandom_range(2);
            end
         end
         pacr_pkg::PH_HOLD, pacr_pkg::PH_WAIT: begin
            if (since_start >= hold_eff) row.busy = (since_start < hold_eff + busy_len);
            since_start++;
         end
         default: begin
            if ($urandom_range(9) < 3) row.cmd = 2'($urandom_range(3));
         end
      endcase
   endtask

   // Runs the sequencer back to idle and lets every outstanding result drain.
   task automatic settle();
      tick_row_type row;
      while (seq_phase != pacr_pkg::PH_IDLE) begin
         row = '0;
         row.cmd = pacr_pkg::CMD_NONE;
         row.bus = 16'($urandom);
         send_tick(row);
      end
      req_tvalid <= 1'b0;
      while (pins_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Upper bits beyond each register's width carry junk and must be ignored.
   task automatic program_registers(input pacr_pkg::cfg_type c);
      logic [pacr_pkg::CSR_DATA_W-1:0] data;
      pacr_pkg::reg_index_type idx;
      for (int i = 0; i < 5; i++) begin
         data = 12'($urandom);
         idx = pacr_pkg::reg_index_type'(i);
         case (idx)
            pacr_pkg::REG_BUSY_TIMEOUT: data[pacr_pkg::TIMEOUT_W-1:0] = c.busy_timeout;
            pacr_pkg::REG_CONVST_HOLD: data[pacr_pkg::HOLD_W-1:0] = c.convst_hold;
            pacr_pkg::REG_RESET_HOLD: data = c.reset_hold;
            pacr_pkg::REG_RANGE_SEL: data[0] = c.range_select;
            default: data[0] = c.reference_select;
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= data;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx)
            pacr_pkg::REG_BUSY_TIMEOUT: cfg.busy_timeout = data[pacr_pkg::TIMEOUT_W-1:0];
            pacr_pkg::REG_CONVST_HOLD: cfg.convst_hold = data[pacr_pkg::HOLD_W-1:0];
            pacr_pkg::REG_RESET_HOLD: cfg.reset_hold = data;
            pacr_pkg::REG_RANGE_SEL: cfg.range_select = data[0];
            default: cfg.reference_select = data[0];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [11:0] want,
                              input logic [11:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
         failures++;
      end
   endtask

   initial begin
      tick_row_type row;
      pacr_pkg::cfg_type c;
      clear_prediction();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            1: begin send_idle_pct = 54; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 54; end
            3: begin send_idle_pct = 7; recv_stall_pct = 7; end
            4: begin send_idle_pct = 54; recv_stall_pct = 54; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         c.range_select = 1'($urandom_range(1));
         c.reference_select = 1'($urandom_range(1));
         c.busy_timeout = 10'($urandom_range(1, 24));
         c.convst_hold = 8'($urandom_range(1, 6));
         c.reset_hold = 12'($urandom_range(1, 40));
         case (p)
            1: c = '{10'd1, 8'd1, 12'd1, 1'b1, 1'b1};
            2: c = '{10'd0, 8'd0, 12'd0, 1'b0, 1'b1};
            3: begin
               c.busy_timeout = 10'd1023;
               c.convst_hold = 8'd255;
               c.reset_hold = 12'd4095;
            end
            default: ;
         endcase
         if (p == 0) begin
            foreach (directed_ticks[i]) send_tick(directed_ticks[i]);
            settle();
         end
         program_registers(c);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 2 && n == ITEMS_PER_PHASE / 2) hold_requests++;
            make_tick(row);
            send_tick(row);
         end
         settle();
      end
      repeat (8) @(posedge clock);
      if (failures == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         rsp_tready <= 1'b0;
         hold_left <= LONG_HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pins_due.size() == 0) begin
            $display("%0t: result beat with none expected, actual tdata %h tuser %b tlast %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            failures++;
         end else begin
            due_beat = pins_due.pop_front();
            check_field("convst_level", due_beat.convst_level, rsp_tdata[0]);
            check_field("chip_select_n", due_beat.chip_select_n, rsp_tdata[1]);
            check_field("read_strobe_n", due_beat.read_strobe_n, rsp_tdata[2]);
            check_field("reset_level", due_beat.reset_level, rsp_tdata[3]);
            check_field("range_level", due_beat.range_level, rsp_tdata[4]);
            check_field("reference_level", due_beat.reference_level, rsp_tdata[5]);
            check_field("channel", due_beat.channel, rsp_tdata[8:6]);
            check_field("sample", due_beat.sample, rsp_tdata[20:9]);
            check_field("timeout_error", due_beat.timeout_error, rsp_tdata[21]);
            check_field("engaged", due_beat.engaged, rsp_tdata[22]);
            check_field("sample_valid", due_beat.sample_valid, rsp_tuser);
            check_field("last_sample", due_beat.last_sample, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
